FILE: hdl/slwm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package slwm_pkg;

  localparam int MAX_LEN = 256;
  localparam int ADDR_W  = $clog2(MAX_LEN);
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CH_ANY_RUN = 8'h25;
  localparam logic [7:0] CH_ANY_ONE = 8'h5F;

  typedef enum logic [1:0] {
    CMD_TEXT = 2'd0,
    CMD_PAT  = 2'd1,
    CMD_EVAL = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_FETCH,
    BS_STEP,
    BS_DONE
  } back_state_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] char_code;
    logic       negate;
  } q_item_t;

  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_head_t;

endpackage
`default_nettype wire

FILE: hdl/sql_like_wildcard_match.sv
`timescale 1ns / 1ps
`default_nettype none
// SQL LIKE matcher: stream in text bytes (command 0) and pattern bytes (command 1), then an
// evaluate transfer (command 2) returns one result with the match bit, inverted when negate
// is set, and the overflow flag; '%' matches any run of bytes, '_' any single byte, no escape.
// Evaluate clears both lengths and the flag. Up to 256 bytes per store, further bytes are
// dropped and flagged. Load transfers are buffered by a two-entry queue in front of the
// match engine. An evaluate occupies the engine for each walk step in turn, each step
// reading both stores through registered memory ports (fetch state, then step state);
// the walk takes up to about (T + 1) * (P + 1) steps for text length T and pattern length P,
// and far fewer on typical data. Command 3 is ignored and gives no result.
module sql_like_wildcard_match
  import slwm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // command[1:0], char_code[9:2], negate[10], zero pad
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata    // matched[0], overflow[1], zero pad
);

  q_head_t head;
  logic    pop;
  logic    res_matched;
  logic    res_overflow;

  slwm_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .in_command_i   (s_axis_tdata[1:0]),
    .in_char_code_i (s_axis_tdata[9:2]),
    .in_negate_i    (s_axis_tdata[10]),
    .head_o         (head),
    .pop_i          (pop)
  );

  slwm_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_matched_o  (res_matched),
    .out_overflow_o (res_overflow)
  );

  assign m_axis_tdata = {6'b0, res_overflow, res_matched};

endmodule
`default_nettype wire

FILE: hdl/slwm_front.sv
`timescale 1ns / 1ps
`default_nettype none
module slwm_front
  import slwm_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] in_command_i,
  input  wire logic [7:0] in_char_code_i,
  input  wire logic       in_negate_i,
  output q_head_t         head_o,
  input  wire logic       pop_i
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  q_item_t           slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              known_cmd;
  logic              push;
  logic              do_pop;
  q_item_t           new_item;

  // unused command code is swallowed here and never reaches the back end
  assign known_cmd  = (in_command_i == CMD_TEXT) || (in_command_i == CMD_PAT) ||
                      (in_command_i == CMD_EVAL);
  assign in_ready_o = (count_q != CNT_W'(QUEUE_DEPTH));
  assign push       = in_valid_i && in_ready_o && known_cmd;
  assign do_pop     = pop_i && (count_q != '0);

  assign new_item.cmd       = cmd_e'(in_command_i);
  assign new_item.char_code = in_char_code_i;
  assign new_item.negate    = in_negate_i;

  assign head_o.valid = (count_q != '0);
  assign head_o.item  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (!push && do_pop) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= new_item;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/slwm_back.sv
`timescale 1ns / 1ps
`default_nettype none
module slwm_back
  import slwm_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire q_head_t head_i,
  output logic         pop_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output logic         out_matched_o,
  output logic         out_overflow_o
);

  logic [7:0] text_mem [MAX_LEN];
  logic [7:0] pat_mem  [MAX_LEN];
  logic [7:0] t_rd_q;
  logic [7:0] p_rd_q;

  back_state_e      state_q, state_d;
  logic [LEN_W-1:0] tlen_q, tlen_d;
  logic [LEN_W-1:0] plen_q, plen_d;
  logic             ovf_q, ovf_d;
  logic [LEN_W-1:0] ti_q, ti_d;
  logic [LEN_W-1:0] pj_q, pj_d;
  logic [LEN_W-1:0] mark_t_q, mark_t_d;
  logic [LEN_W-1:0] mark_p_q, mark_p_d;
  logic             mark_q, mark_d;
  logic             neg_q, neg_d;
  logic             match_q, match_d;
  logic             out_valid_q, out_valid_d;
  logic             out_matched_q, out_matched_d;
  logic             out_ovf_q, out_ovf_d;

  logic t_we, p_we;
  logic t_active, p_ok, p_run, p_hit, step_done, out_free;

  assign pop_o  = (state_q == BS_IDLE) && head_i.valid;
  assign t_we   = pop_o && (head_i.item.cmd == CMD_TEXT) && (tlen_q < LEN_W'(MAX_LEN));
  assign p_we   = pop_o && (head_i.item.cmd == CMD_PAT) && (plen_q < LEN_W'(MAX_LEN));

  assign t_active  = (ti_q < tlen_q);
  assign p_ok      = (pj_q < plen_q);
  assign p_run     = p_ok && (p_rd_q == CH_ANY_RUN);
  assign p_hit     = p_ok && ((p_rd_q == CH_ANY_ONE) || (p_rd_q == t_rd_q));
  assign step_done = t_active ? (!p_run && !p_hit && !mark_q) : !p_run;
  assign out_free  = !out_valid_q || out_ready_i;

  // stores: one write port, one registered read port each
  always_ff @(posedge clk_i) begin
    if (t_we) begin
      text_mem[tlen_q[ADDR_W-1:0]] <= head_i.item.char_code;
    end
    t_rd_q <= text_mem[ti_q[ADDR_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (p_we) begin
      pat_mem[plen_q[ADDR_W-1:0]] <= head_i.item.char_code;
    end
    p_rd_q <= pat_mem[pj_q[ADDR_W-1:0]];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      BS_IDLE: begin
        if (head_i.valid && head_i.item.cmd == CMD_EVAL) begin
          state_d = BS_FETCH;
        end
      end
      BS_FETCH: state_d = BS_STEP;
      BS_STEP: begin
        state_d = step_done ? BS_DONE : BS_FETCH;
      end
      BS_DONE: begin
        if (out_free) begin
          state_d = BS_IDLE;
        end
      end
      default: state_d = BS_IDLE;
    endcase
  end

  always_comb begin
    tlen_d        = tlen_q;
    plen_d        = plen_q;
    ovf_d         = ovf_q;
    ti_d          = ti_q;
    pj_d          = pj_q;
    mark_t_d      = mark_t_q;
    mark_p_d      = mark_p_q;
    mark_d        = mark_q;
    neg_d         = neg_q;
    match_d       = match_q;
    out_valid_d   = out_valid_q;
    out_matched_d = out_matched_q;
    out_ovf_d     = out_ovf_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      BS_IDLE: begin
        if (pop_o) begin
          case (head_i.item.cmd)
            CMD_TEXT: begin
              if (t_we) begin
                tlen_d = tlen_q + LEN_W'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            CMD_PAT: begin
              if (p_we) begin
                plen_d = plen_q + LEN_W'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            CMD_EVAL: begin
              ti_d   = '0;
              pj_d   = '0;
              mark_d = 1'b0;
              neg_d  = head_i.item.negate;
            end
            default: ;
          endcase
        end
      end
      BS_STEP: begin
        if (t_active) begin
          if (p_run) begin
            mark_d   = 1'b1;
            mark_t_d = ti_q;
            mark_p_d = pj_q;
            pj_d     = pj_q + LEN_W'(1);
          end else if (p_hit) begin
            ti_d = ti_q + LEN_W'(1);
            pj_d = pj_q + LEN_W'(1);
          end else if (mark_q) begin
            // let the last wildcard run swallow one more text byte
            mark_t_d = mark_t_q + LEN_W'(1);
            ti_d     = mark_t_q + LEN_W'(1);
            pj_d     = mark_p_q + LEN_W'(1);
          end else begin
            match_d = 1'b0;
          end
        end else if (p_run) begin
          pj_d = pj_q + LEN_W'(1);
        end else begin
          match_d = !p_ok;
        end
      end
      BS_DONE: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_matched_d = match_q ^ neg_q;
          out_ovf_d     = ovf_q;
          tlen_d        = '0;
          plen_d        = '0;
          ovf_d         = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BS_IDLE;
      tlen_q      <= '0;
      plen_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      mark_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      tlen_q      <= tlen_d;
      plen_q      <= plen_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      mark_q      <= mark_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ti_q          <= ti_d;
    pj_q          <= pj_d;
    mark_t_q      <= mark_t_d;
    mark_p_q      <= mark_p_d;
    neg_q         <= neg_d;
    match_q       <= match_d;
    out_matched_q <= out_matched_d;
    out_ovf_q     <= out_ovf_d;
  end

  assign out_valid_o    = out_valid_q;
  assign out_matched_o  = out_matched_q;
  assign out_overflow_o = out_ovf_q;

endmodule
`default_nettype wire
